@@ src/fl_ptw_pkg.sv @@
`timescale 1ns / 1ps

package fl_ptw_pkg;

    localparam int POOL_PAGES_DEF = 64;

    localparam int IDX_W = 9;
    localparam int ENT_PER_PAGE = 512;
    localparam int PFN_W = 40;

    localparam logic [63:0] ADDR_MASK = 64'h000f_ffff_ffff_f000;
    localparam logic [11:0] PTR_FLAGS = 12'h007;

    localparam logic [2:0] MODE_MAP = 3'd0;
    localparam logic [2:0] MODE_SET_FLAGS = 3'd1;
    localparam logic [2:0] MODE_UNMAP = 3'd2;
    localparam logic [2:0] MODE_XLATE = 3'd3;
    localparam logic [2:0] MODE_READ = 3'd4;
    localparam logic [2:0] MODE_READ_CREATE = 3'd5;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [1:0] ST_PRESENT = 2'd2;
    localparam logic [1:0] ST_UNMAPPED = 2'd3;

    localparam logic [0:0] REG_POOL_BASE = 1'b0;

    typedef struct packed {
        logic [2:0]  mode;
        logic [47:0] virt_addr;
        logic [63:0] phys_addr;
        logic [63:0] flags;
    } req_t;

    typedef struct packed {
        logic        ok;
        logic [1:0]  status;
        logic [63:0] entry_value;
        logic        tlb_flush;
    } rsp_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_CLR_ALL,
        OP_LOAD,
        OP_READ,
        OP_ALLOC,
        OP_ZERO,
        OP_SETPG,
        OP_DESCEND,
        OP_UPDATE,
        OP_XLATE,
        OP_READV,
        OP_MAPWR,
        OP_FAIL_UNM,
        OP_FAIL_EXH,
        OP_FAIL_PRES,
        OP_DONE
    } op_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_SWEEP_BUSY,
        C_NO_START,
        C_BAD_MODE,
        C_IS_LEAF,
        C_PRESENT,
        C_NO_CREATE,
        C_POOL_FULL,
        C_PAGE_BUSY,
        C_PTR_IN,
        C_IS_MAP,
        C_IS_READ,
        C_ABSENT,
        C_IS_XLATE
    } cond_t;

    typedef logic [4:0] step_t;

    localparam step_t U_CLR_ALL = 5'd0;
    localparam step_t U_IDLE = 5'd1;
    localparam step_t U_DISP = 5'd2;
    localparam step_t U_RD = 5'd3;
    localparam step_t U_TEST = 5'd4;
    localparam step_t U_PTR = 5'd5;
    localparam step_t U_MISS = 5'd6;
    localparam step_t U_FULL = 5'd7;
    localparam step_t U_ALLOC = 5'd8;
    localparam step_t U_ZERO = 5'd9;
    localparam step_t U_DESC = 5'd10;
    localparam step_t U_FOLLOW = 5'd11;
    localparam step_t U_F_UNM = 5'd12;
    localparam step_t U_F_EXH = 5'd13;
    localparam step_t U_F_PRES = 5'd14;
    localparam step_t U_LEAF = 5'd15;
    localparam step_t U_LEAF2 = 5'd16;
    localparam step_t U_LEAF3 = 5'd17;
    localparam step_t U_LEAF4 = 5'd18;
    localparam step_t U_UPD = 5'd19;
    localparam step_t U_XL = 5'd20;
    localparam step_t U_READL = 5'd21;
    localparam step_t U_MAPL = 5'd22;
    localparam step_t U_MAPW = 5'd23;
    localparam step_t U_DONE = 5'd24;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ucw_t;

    // Microprogram: jump to target when cond holds, else fall through.
    function automatic ucw_t ucode(input step_t step);
        ucw_t w;
        case (step)
            U_CLR_ALL: w = '{OP_CLR_ALL,   C_SWEEP_BUSY, U_CLR_ALL};
            U_IDLE:    w = '{OP_LOAD,      C_NO_START,   U_IDLE};
            U_DISP:    w = '{OP_NOP,       C_BAD_MODE,   U_DONE};
            U_RD:      w = '{OP_READ,      C_NEVER,      U_IDLE};
            U_TEST:    w = '{OP_NOP,       C_IS_LEAF,    U_LEAF};
            U_PTR:     w = '{OP_NOP,       C_PRESENT,    U_FOLLOW};
            U_MISS:    w = '{OP_NOP,       C_NO_CREATE,  U_F_UNM};
            U_FULL:    w = '{OP_NOP,       C_POOL_FULL,  U_F_EXH};
            U_ALLOC:   w = '{OP_ALLOC,     C_NEVER,      U_IDLE};
            U_ZERO:    w = '{OP_ZERO,      C_PAGE_BUSY,  U_ZERO};
            U_DESC:    w = '{OP_DESCEND,   C_ALWAYS,     U_RD};
            U_FOLLOW:  w = '{OP_SETPG,     C_PTR_IN,     U_DESC};
            U_F_UNM:   w = '{OP_FAIL_UNM,  C_ALWAYS,     U_DONE};
            U_F_EXH:   w = '{OP_FAIL_EXH,  C_ALWAYS,     U_DONE};
            U_F_PRES:  w = '{OP_FAIL_PRES, C_ALWAYS,     U_DONE};
            U_LEAF:    w = '{OP_NOP,       C_IS_MAP,     U_MAPL};
            U_LEAF2:   w = '{OP_NOP,       C_IS_READ,    U_READL};
            U_LEAF3:   w = '{OP_NOP,       C_ABSENT,     U_F_UNM};
            U_LEAF4:   w = '{OP_NOP,       C_IS_XLATE,   U_XL};
            U_UPD:     w = '{OP_UPDATE,    C_ALWAYS,     U_DONE};
            U_XL:      w = '{OP_XLATE,     C_ALWAYS,     U_DONE};
            U_READL:   w = '{OP_READV,     C_ALWAYS,     U_DONE};
            U_MAPL:    w = '{OP_NOP,       C_PRESENT,    U_F_PRES};
            U_MAPW:    w = '{OP_MAPWR,     C_NEVER,      U_IDLE};
            U_DONE:    w = '{OP_DONE,      C_ALWAYS,     U_IDLE};
            default:   w = '{OP_NOP,       C_ALWAYS,     U_IDLE};
        endcase
        return w;
    endfunction

endpackage

@@ src/four_level_page_table_update_walk_unit.sv @@
`timescale 1ns / 1ps

// Channel  | Signals                                  | Transaction
// ---------+------------------------------------------+------------------------------------
// request  | start, busy, req (req_t)                 | start high while busy low
// result   | done, rsp (rsp_t)                        | done high for one cycle, no stall
// config   | psel penable pwrite paddr pwdata prdata  | write on psel&penable&pwrite&pready
//
// A microcoded sequencer walks the levels with one read per level on the single table port.
// A full walk holds busy through dispatch, then the read, test, check, follow and descend steps
// of each pointer level and the leaf steps; failures end sooner. The result strobe follows in
// the next cycle, where busy is already low. Each level created also zeroes its new page.
// After reset a clearing pass writes all POOL_PAGES*512 entries, one per cycle, with busy high.
// The receiver cannot stall results; configuration writes are taken at any time.
module four_level_page_table_update_walk_unit
    import fl_ptw_pkg::*;
#(
    parameter int POOL_PAGES = POOL_PAGES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // request
    input  logic        start,
    output logic        busy,
    input  req_t        req,
    // result
    output logic        done,
    output rsp_t        rsp,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int PG_W = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
    localparam int NFP_W = $clog2(POOL_PAGES + 1);
    localparam int AW = PG_W + IDX_W;
    localparam int DEPTH = POOL_PAGES * ENT_PER_PAGE;

    // byte address of the pool base register (registers sit 8 bytes apart)
    localparam logic [2:0] POOL_BASE_PADDR = 3'(REG_POOL_BASE * 8);

    // table storage, single write / single registered read
    logic [63:0] mem [DEPTH];

    // sequencer
    step_t upc_reg, upc_next;
    ucw_t uw;
    logic cond_hit;

    // control registers
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [NFP_W-1:0] nfp_reg, nfp_next;
    logic [PFN_W-1:0] base_reg, base_next;
    logic done_reg, done_next;

    // request / walk registers
    req_t req_reg, req_next;
    logic [PG_W-1:0] pg_reg, pg_next;
    logic [1:0] lvl_reg, lvl_next;
    logic [63:0] rd_data_reg;
    rsp_t rsp_reg, rsp_next;

    // memory port
    logic mem_we;
    logic mem_re;
    logic [AW-1:0] mem_addr;
    logic [63:0] mem_wdata;

    // walk decode
    logic [IDX_W-1:0] idx;
    logic [PFN_W-1:0] ptr_off;
    logic ptr_in;
    logic present;
    logic create;
    logic cfg_wr;

    assign uw = ucode(upc_reg);
    assign present = rd_data_reg[0];
    assign create = (req_reg.mode == MODE_MAP) || (req_reg.mode == MODE_READ_CREATE);

    // per-level index from VA bits 47:39, 38:30, 29:21, 20:12
    always_comb
    begin
        case (lvl_reg)
            2'd3:    idx = req_reg.virt_addr[47:39];
            2'd2:    idx = req_reg.virt_addr[38:30];
            2'd1:    idx = req_reg.virt_addr[29:21];
            default: idx = req_reg.virt_addr[20:12];
        endcase
    end

    // pointer entry -> pool page, relative to the configured base
    assign ptr_off = rd_data_reg[51:12] - base_reg;
    assign ptr_in = ptr_off < PFN_W'(POOL_PAGES);

    always_comb
    begin
        case (uw.cond)
            C_NEVER:      cond_hit = 1'b0;
            C_ALWAYS:     cond_hit = 1'b1;
            C_SWEEP_BUSY: cond_hit = clr_cnt_reg != AW'(DEPTH - 1);
            C_NO_START:   cond_hit = !start;
            C_BAD_MODE:   cond_hit = req_reg.mode > MODE_READ_CREATE;
            C_IS_LEAF:    cond_hit = lvl_reg == 2'd0;
            C_PRESENT:    cond_hit = present;
            C_NO_CREATE:  cond_hit = !create;
            C_POOL_FULL:  cond_hit = nfp_reg >= NFP_W'(POOL_PAGES);
            C_PAGE_BUSY:  cond_hit = clr_cnt_reg[IDX_W-1:0] != {IDX_W{1'b1}};
            C_PTR_IN:     cond_hit = ptr_in;
            C_IS_MAP:     cond_hit = req_reg.mode == MODE_MAP;
            C_IS_READ:    cond_hit = (req_reg.mode == MODE_READ)
                                     || (req_reg.mode == MODE_READ_CREATE);
            C_ABSENT:     cond_hit = !present;
            C_IS_XLATE:   cond_hit = req_reg.mode == MODE_XLATE;
            default:      cond_hit = 1'b0;
        endcase
    end

    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        upc_next = cond_hit ? uw.target : upc_reg + step_t'(1);
        clr_cnt_next = clr_cnt_reg;
        nfp_next = nfp_reg;
        base_next = base_reg;
        done_next = 1'b0;
        req_next = req_reg;
        pg_next = pg_reg;
        lvl_next = lvl_reg;
        rsp_next = rsp_reg;
        mem_we = 1'b0;
        mem_re = 1'b0;
        mem_addr = {pg_reg, idx};
        mem_wdata = '0;

        if (cfg_wr && (paddr == POOL_BASE_PADDR))
        begin
            base_next = pwdata[51:12];
        end

        case (uw.op)
            OP_CLR_ALL:
            begin
                mem_we = 1'b1;
                mem_addr = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + AW'(1);
            end
            OP_LOAD:
            begin
                if (start)
                begin
                    req_next = req;
                    pg_next = '0;
                    lvl_next = 2'd3;
                    rsp_next = '0;
                end
            end
            OP_READ:
            begin
                mem_re = 1'b1;
            end
            OP_ALLOC:
            begin
                // parent entry -> new page, present | writable | user
                mem_we = 1'b1;
                mem_wdata = {12'h000, base_reg + PFN_W'(nfp_reg), PTR_FLAGS};
                pg_next = PG_W'(nfp_reg);
                nfp_next = nfp_reg + NFP_W'(1);
                clr_cnt_next = '0;
            end
            OP_ZERO:
            begin
                mem_we = 1'b1;
                mem_addr = {pg_reg, clr_cnt_reg[IDX_W-1:0]};
                clr_cnt_next = clr_cnt_reg + AW'(1);
            end
            OP_SETPG:
            begin
                pg_next = ptr_off[PG_W-1:0];
            end
            OP_DESCEND:
            begin
                lvl_next = lvl_reg - 2'd1;
            end
            OP_UPDATE:
            begin
                mem_we = 1'b1;
                mem_wdata = (req_reg.mode == MODE_SET_FLAGS)
                            ? ((rd_data_reg & ADDR_MASK) | req_reg.flags) : 64'd0;
                rsp_next.ok = 1'b1;
                rsp_next.tlb_flush = 1'b1;
            end
            OP_XLATE:
            begin
                rsp_next.entry_value = rd_data_reg & ADDR_MASK;
                rsp_next.ok = 1'b1;
            end
            OP_READV:
            begin
                rsp_next.entry_value = rd_data_reg;
                rsp_next.ok = 1'b1;
            end
            OP_MAPWR:
            begin
                mem_we = 1'b1;
                mem_wdata = req_reg.phys_addr | req_reg.flags;
                rsp_next.ok = 1'b1;
            end
            OP_FAIL_UNM:  rsp_next.status = ST_UNMAPPED;
            OP_FAIL_EXH:  rsp_next.status = ST_EXHAUSTED;
            OP_FAIL_PRES: rsp_next.status = ST_PRESENT;
            OP_DONE:      done_next = 1'b1;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= U_CLR_ALL;
            clr_cnt_reg <= '0;
            nfp_reg <= NFP_W'(1);
            base_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            upc_reg <= upc_next;
            clr_cnt_reg <= clr_cnt_next;
            nfp_reg <= nfp_next;
            base_reg <= base_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        pg_reg <= pg_next;
        lvl_reg <= lvl_next;
        rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    assign busy = upc_reg != U_IDLE;
    assign done = done_reg;
    assign rsp = rsp_reg;
    assign pready = 1'b1;
    assign prdata = (paddr == POOL_BASE_PADDR) ? {12'h000, base_reg, 12'h000} : 64'd0;

    // a result strobe lasts a single cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("done held longer than one cycle");

    // flush only on success, and success always reports ok status
    a_flush_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.tlb_flush) |-> (rsp.ok && (rsp.status == ST_OK)))
        else $error("tlb_flush on failed request");

    a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.ok) |-> (rsp.status == ST_OK))
        else $error("ok with error status");

    // bump pointer never runs past the pool
    a_nfp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nfp_reg <= NFP_W'(POOL_PAGES))
        else $error("next free page beyond pool");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but sequencer idle");

endmodule

@@ bench/four_level_page_table_update_walk_unit_tb.sv @@
`timescale 1ns / 1ps

// Testbench for the four-level page table walk unit.
// Requests go in through start/busy. Each accepted request is run through a
// predictor that keeps its own copy of the table pool, so every done pulse is
// checked field by field against the expected response.
module four_level_page_table_update_walk_unit_tb;
    import fl_ptw_pkg::*;

    localparam int POOL_PAGES = POOL_PAGES_DEF;
    localparam int LIMIT_CYCLES = 1_000_000;

    // Modes 6 and 7 are undefined: the block must answer ok 0, status 0.
    localparam logic [2:0] MODE_RSVD_A = 3'd6;
    localparam logic [2:0] MODE_RSVD_B = 3'd7;

    // Registers sit 8 bytes apart; the pool base register holds address bits 51:12.
    localparam logic [2:0] POOL_BASE_ADDR = 3'(REG_POOL_BASE * 8);
    localparam logic [63:0] BASE_TOP = 64'h000f_ffff_ffff_f000;
    localparam logic [47:0] VA_TOP = 48'hffff_ffff_ffff;

    // Predictor plus the queue of responses still owed by the block.
    class walk_scoreboard;
        logic [63:0] table_mem [POOL_PAGES*ENT_PER_PAGE];
        int unsigned next_page;
        logic [63:0] pool_base;
        rsp_t        expected_walk_rsp [$];
        int          errors;
        int          checked;
        int          status_seen [4];
        int          flushes;

        function new();
            foreach (table_mem[i]) table_mem[i] = '0;
            foreach (status_seen[i]) status_seen[i] = 0;
            next_page = 1;
            pool_base = '0;
            errors = 0;
            checked = 0;
            flushes = 0;
        endfunction

        function void set_base(logic [63:0] value);
            pool_base = value & ADDR_MASK;
        endfunction

        function int pending();
            return expected_walk_rsp.size();
        endfunction

        // Follow the pointer in one slot, or allocate the level below it.
        function logic [1:0] descend(int unsigned slot, bit create, output int unsigned pg);
            logic [63:0] e;
            logic [63:0] off;
            int unsigned np;
            int          i;
            pg = 0;
            e = table_mem[slot];
            if (e[0])
            begin
                off = ((e & ADDR_MASK) - pool_base) & ADDR_MASK;
                if ((off >> 12) >= 64'(POOL_PAGES))
                    return ST_UNMAPPED;     // pointer lands outside the pool
                pg = 32'(off >> 12);
                return ST_OK;
            end
            if (!create)
                return ST_UNMAPPED;
            if (next_page >= POOL_PAGES)
                return ST_EXHAUSTED;
            np = next_page;
            next_page++;
            for (i = 0; i < ENT_PER_PAGE; i++)
                table_mem[np*ENT_PER_PAGE + i] = '0;
            table_mem[slot] = ((pool_base + (64'(np) << 12)) & ADDR_MASK) | 64'(PTR_FLAGS);
            pg = np;
            return ST_OK;
        endfunction

        function logic [1:0] find_leaf(logic [47:0] va, bit create, output int unsigned leaf);
            int unsigned pg;
            int unsigned nxt;
            logic [1:0]  st;
            int          lvl;
            pg = 0;
            leaf = 0;
            for (lvl = 3; lvl >= 1; lvl--)
            begin
                st = descend(pg*ENT_PER_PAGE + 32'(va[12+9*lvl +: 9]), create, nxt);
                if (st != ST_OK)
                    return st;
                pg = nxt;
            end
            leaf = pg*ENT_PER_PAGE + 32'(va[20:12]);
            return ST_OK;
        endfunction

        // Expected response of one accepted request; updates the table copy.
        function void note_request(req_t r);
            rsp_t        w;
            int unsigned leaf;
            logic [1:0]  st;
            w = '0;
            st = ST_OK;
            case (r.mode)
                MODE_MAP:
                begin
                    st = find_leaf(r.virt_addr, 1'b1, leaf);
                    if (st == ST_OK)
                    begin
                        if (table_mem[leaf][0])
                            st = ST_PRESENT;
                        else
                        begin
                            table_mem[leaf] = r.phys_addr | r.flags;
                            w.ok = 1'b1;
                        end
                    end
                end
                MODE_SET_FLAGS, MODE_UNMAP:
                begin
                    st = find_leaf(r.virt_addr, 1'b0, leaf);
                    if (st == ST_OK)
                    begin
                        if (!table_mem[leaf][0])
                            st = ST_UNMAPPED;
                        else
                        begin
                            table_mem[leaf] = (r.mode == MODE_SET_FLAGS) ?
                                ((table_mem[leaf] & ADDR_MASK) | r.flags) : '0;
                            w.ok = 1'b1;
                            w.tlb_flush = 1'b1;
                        end
                    end
                end
                MODE_XLATE:
                begin
                    st = find_leaf(r.virt_addr, 1'b0, leaf);
                    if (st == ST_OK)
                    begin
                        if (!table_mem[leaf][0])
                            st = ST_UNMAPPED;
                        else
                        begin
                            w.entry_value = table_mem[leaf] & ADDR_MASK;
                            w.ok = 1'b1;
                        end
                    end
                end
                MODE_READ, MODE_READ_CREATE:
                begin
                    st = find_leaf(r.virt_addr, r.mode == MODE_READ_CREATE, leaf);
                    if (st == ST_OK)
                    begin
                        w.entry_value = table_mem[leaf];
                        w.ok = 1'b1;
                    end
                end
                default: ;
            endcase
            w.status = st;
            expected_walk_rsp.push_back(w);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            $display("[%0t] walk unit %s: got %h, want %h", $time, what, got, want);
        endtask

        task check_result(rsp_t got);
            rsp_t want;
            checked++;
            if (!$isunknown(got.status))
                status_seen[got.status]++;
            if (got.tlb_flush === 1'b1)
                flushes++;
            if (expected_walk_rsp.size() == 0)
            begin
                report("response with no request", got.entry_value, '0);
                return;
            end
            want = expected_walk_rsp.pop_front();
            if (got.ok !== want.ok)
                report("ok", 64'(got.ok), 64'(want.ok));
            if (got.status !== want.status)
                report("status", 64'(got.status), 64'(want.status));
            if (got.entry_value !== want.entry_value)
                report("entry_value", got.entry_value, want.entry_value);
            if (got.tlb_flush !== want.tlb_flush)
                report("tlb_flush", 64'(got.tlb_flush), 64'(want.tlb_flush));
        endtask

        task flush_leftover();
            rsp_t want;
            while (expected_walk_rsp.size() != 0)
            begin
                want = expected_walk_rsp.pop_front();
                report("response never produced", '0, want.entry_value);
            end
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    req_t        req;
    logic        done;
    rsp_t        rsp;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    walk_scoreboard sb;
    int          cycles = 0;
    int          requests_sent = 0;
    int          base_settings = 0;
    bit          idle_on;
    // Virtual regions (bits 47:21) that most random requests land in, so maps,
    // lookups and unmaps keep hitting the same leaf tables.
    logic [47:21] region [16];

    four_level_page_table_update_walk_unit #(
        .POOL_PAGES (POOL_PAGES)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .req     (req),
        .done    (done),
        .rsp     (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 clk = ~clk;

    // Watchdog: covers the clearing pass, every level creation and all items
    // many times over.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Results cannot be stalled: grab every done pulse at the edge ending it.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
            sb.check_result(rsp);
    end

    // One request transaction. start stays high from the previous item if the
    // caller sends back to back; the predictor runs at the accepting edge.
    task send(req_t r);
        @(negedge clk);
        start = 1'b1;
        req = r;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_request(r);
        requests_sent++;
    endtask

    task idle_gap(int n);
        @(negedge clk);
        start = 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Let everything outstanding drain before touching configuration.
    task quiesce();
        @(negedge clk);
        start = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
    endtask

    // APB write of the pool base, then a read back of the address bits.
    task set_pool_base(logic [63:0] value);
        logic [63:0] got;
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = POOL_BASE_ADDR;
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        sb.set_base(value);
        base_settings++;
        @(negedge clk);
        penable = 1'b0;
        pwrite = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        got = prdata;
        if ((got & ADDR_MASK) !== sb.pool_base)
            sb.report("pool base read back", got, sb.pool_base);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    function automatic req_t mk(logic [2:0] mode, logic [47:0] va, logic [63:0] pa,
                                logic [63:0] fl);
        req_t r;
        r.mode = mode;
        r.virt_addr = va;
        r.phys_addr = pa;
        r.flags = fl;
        return r;
    endfunction

    // Random request. fresh_div sets how often a map or creating read goes to
    // a brand-new address, which is what eats table pages.
    function automatic req_t make_item(int fresh_div);
        req_t       r;
        int         pick;
        logic [8:0] leaf_idx;
        bit         fresh;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            r.mode = MODE_MAP;
        else if (pick < 45)
            r.mode = MODE_SET_FLAGS;
        else if (pick < 57)
            r.mode = MODE_UNMAP;
        else if (pick < 75)
            r.mode = MODE_XLATE;
        else if (pick < 87)
            r.mode = MODE_READ;
        else if (pick < 95)
            r.mode = MODE_READ_CREATE;
        else
            r.mode = pick[0] ? MODE_RSVD_A : MODE_RSVD_B;
        case ($urandom_range(0, 9))
            0:       leaf_idx = '1;
            1, 2:    leaf_idx = 9'($urandom);
            default: leaf_idx = 9'($urandom_range(0, 7));
        endcase
        r.virt_addr = {region[$urandom_range(0, 15)], leaf_idx, 12'($urandom)};
        if (r.mode == MODE_MAP || r.mode == MODE_READ_CREATE)
            fresh = ($urandom_range(1, fresh_div) == 1);
        else
            fresh = ($urandom_range(0, 7) == 0);
        if (fresh)
            r.virt_addr = 48'({$urandom, $urandom});
        r.phys_addr = {$urandom, $urandom};
        r.flags = {$urandom, $urandom};
        // mostly write present leaves so later lookups find something
        if ($urandom_range(0, 4) != 0)
            r.flags[0] = 1'b1;
        return r;
    endfunction

    // Random stretch; idling switches on and off in blocks of 40 requests and
    // is off entirely for the closing 150 when quiet_tail is set.
    task run_phase(int count, int fresh_div, bit quiet_tail);
        int n;
        for (n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
                idle_on = ($urandom_range(0, 2) != 0);
            if (quiet_tail && n >= count - 150)
                idle_on = 1'b0;
            if (idle_on && $urandom_range(0, 2) == 0)
                idle_gap($urandom_range(1, 4));
            send(make_item(fresh_div));
        end
    endtask

    initial
    begin
        req_t        directed [$];
        logic [8:0]  l4 [4];
        int          i;

        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sb = new();

        // Regions share their top-level index four at a time; the first is
        // all zeros and the second all ones in the upper bits.
        for (i = 0; i < 4; i++)
            l4[i] = 9'($urandom);
        l4[0] = '0;
        l4[1] = '1;
        for (i = 0; i < 16; i++)
            region[i] = {l4[i % 4], 18'($urandom)};
        region[0] = '0;
        region[1] = '1;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Base zero, with junk in the ignored low bits. The first request then
        // waits out the clearing pass on busy.
        set_pool_base(64'(12'($urandom)));

        // Directed: empty-table misses, creating reads, map over a present leaf,
        // flags that drop the present bit, unmap twice, undefined modes.
        directed.push_back(mk(MODE_XLATE, '0, '0, '0));
        directed.push_back(mk(MODE_UNMAP, '0, '0, '0));
        directed.push_back(mk(MODE_SET_FLAGS, '0, '0, 64'h1));
        directed.push_back(mk(MODE_READ, '0, '0, '0));
        directed.push_back(mk(MODE_READ_CREATE, VA_TOP, '0, '0));
        directed.push_back(mk(MODE_MAP, VA_TOP, '1, '1));
        directed.push_back(mk(MODE_MAP, VA_TOP, '0, 64'h1));
        directed.push_back(mk(MODE_XLATE, VA_TOP, '0, '0));
        directed.push_back(mk(MODE_READ, VA_TOP, '0, '0));
        directed.push_back(mk(MODE_SET_FLAGS, VA_TOP, '1, '0));
        directed.push_back(mk(MODE_XLATE, VA_TOP, '0, '0));
        directed.push_back(mk(MODE_READ, VA_TOP, '0, '0));
        directed.push_back(mk(MODE_MAP, VA_TOP, 64'h0000_0000_0005_5000, 64'h3));
        directed.push_back(mk(MODE_UNMAP, VA_TOP, '0, '0));
        directed.push_back(mk(MODE_UNMAP, VA_TOP, '0, '0));
        directed.push_back(mk(MODE_MAP, '0, '0, 64'h1));
        directed.push_back(mk(MODE_XLATE, '0, '0, '0));
        directed.push_back(mk(MODE_MAP, 48'h0000_0000_1000, '1, '0));
        directed.push_back(mk(MODE_SET_FLAGS, 48'h0000_0000_1000, '0, '1));
        directed.push_back(mk(MODE_READ, 48'h0000_0000_1000, '0, '0));
        directed.push_back(mk(MODE_READ_CREATE, 48'h8000_0000_0000, '0, '0));
        directed.push_back(mk(MODE_RSVD_A, VA_TOP, '1, '1));
        directed.push_back(mk(MODE_RSVD_B, '0, '1, '1));
        directed.push_back(mk(MODE_READ, 48'h0000_0020_0000, '0, '0));
        foreach (directed[i])
        begin
            if ($urandom_range(0, 2) == 0)
                idle_gap($urandom_range(1, 4));
            send(directed[i]);
        end

        // Base zero: build up the regions with a slow trickle of new addresses.
        run_phase(420, 20, 1'b0);

        // Top base: old pointers now resolve one page higher, and a pointer to
        // the last page falls outside the pool.
        quiesce();
        set_pool_base(BASE_TOP);
        run_phase(150, 20, 1'b0);

        // Random base: old pointers mostly land outside the pool.
        quiesce();
        set_pool_base({12'h000, 40'({$urandom, $urandom}), 12'($urandom)});
        run_phase(130, 20, 1'b0);

        // Back to base zero, burning through what is left of the pool.
        quiesce();
        set_pool_base(64'(12'($urandom)));
        run_phase(350, 6, 1'b1);

        @(negedge clk);
        start = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        sb.flush_leftover();

        $display("covered %0d requests under %0d pool base settings, %0d of %0d pages allocated",
                 requests_sent, base_settings, sb.next_page, POOL_PAGES);
        $display("responses: %0d status ok, %0d exhausted, %0d present, %0d unmapped, %0d flushes",
                 sb.status_seen[ST_OK], sb.status_seen[ST_EXHAUSTED],
                 sb.status_seen[ST_PRESENT], sb.status_seen[ST_UNMAPPED], sb.flushes);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ four_level_page_table_update_walk_unit.f @@
src/fl_ptw_pkg.sv
src/four_level_page_table_update_walk_unit.sv
bench/four_level_page_table_update_walk_unit_tb.sv
